### rtl/pps_pkg.sv
// Shared types, field widths and helper functions of the preemptive priority scheduler.
`default_nettype none
package pps_pkg;

	localparam int MAX_PROCS_DEF = 32;

	localparam int ARR_W  = 16;
	localparam int BUR_W  = 16;
	localparam int PRI_W  = 8;
	localparam int PIDX_W = 5;
	localparam int TIME_W = 22;
	localparam int SUM_W  = 27;

	typedef struct packed {
		logic [PRI_W-1:0] pri;
		logic [BUR_W-1:0] bur;
		logic [ARR_W-1:0] arr;
	} rec_t;

	// status of the selection unit after a scan
	typedef struct packed {
		logic             have;
		logic             have_next;
		logic [ARR_W-1:0] next_arr;
		logic [BUR_W-1:0] rem;
		logic [BUR_W-1:0] bur;
	} pick_t;

	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// width of the latest possible tick: last arrival plus every burst
	function automatic int tick_w(input int n);
		return $clog2((n + 1) * (1 << ARR_W));
	endfunction

endpackage
`default_nettype wire

### rtl/pps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = pps_pkg::idx_w(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/pps_pick.sv
// Compare unit that walks the process table and keeps the best runnable process and next arrival.
`default_nettype none
module pps_pick #(
	parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
	localparam int IDX_W  = pps_pkg::idx_w(MAX_PROCS),
	localparam int TICK_W = pps_pkg::tick_w(MAX_PROCS)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      clr,
	input  wire logic                      vld,
	input  wire logic [IDX_W-1:0]          idx,
	input  wire pps_pkg::rec_t             rec,
	input  wire logic [pps_pkg::BUR_W-1:0] rem,
	input  wire logic                      done,
	input  wire logic [TICK_W-1:0]         tick,
	output logic      [IDX_W-1:0]          best_idx,
	output pps_pkg::pick_t                 stat
);

	logic                      have_q;
	logic                      have_next_q;
	logic [IDX_W-1:0]          bidx_q;
	logic [pps_pkg::PRI_W-1:0] bpri_q;
	logic [pps_pkg::ARR_W-1:0] barr_q;
	logic [pps_pkg::BUR_W-1:0] brem_q;
	logic [pps_pkg::BUR_W-1:0] bbur_q;
	logic [pps_pkg::ARR_W-1:0] next_q;

	logic arrived;
	logic better;
	logic take_best;
	logic take_next;

	assign arrived = TICK_W'(rec.arr) <= tick;
	assign better  = !have_q || (rec.pri < bpri_q) ||
	                 ((rec.pri == bpri_q) && (rec.arr < barr_q));
	assign take_best = vld && !done && arrived && better;
	assign take_next = vld && !done && !arrived && (!have_next_q || (rec.arr < next_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			have_next_q <= 1'b0;
		end else if (clr) begin
			have_q      <= 1'b0;
			have_next_q <= 1'b0;
		end else begin
			if (take_best) begin
				have_q <= 1'b1;
			end
			if (take_next) begin
				have_next_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!clr && take_best) begin
			bidx_q <= idx;
			bpri_q <= rec.pri;
			barr_q <= rec.arr;
			brem_q <= rem;
			bbur_q <= rec.bur;
		end
		if (!clr && take_next) begin
			next_q <= rec.arr;
		end
	end

	assign best_idx       = bidx_q;
	assign stat.have      = have_q;
	assign stat.have_next = have_next_q;
	assign stat.next_arr  = next_q;
	assign stat.rem       = brem_q;
	assign stat.bur       = bbur_q;

endmodule
`default_nettype wire

### rtl/preemptive_priority_scheduler.sv
// Top level: record loading, scheduling sequencer and result output of the priority scheduler.
//
// Process records load one per cycle while rec_ready is high; the record with last_record set
// starts the run, and rec_ready stays low until the last result has been taken. Records beyond
// MAX_PROCS are dropped. Each scheduling decision scans the N loaded records through one
// compare unit (SCAN, SDRAIN); if one is runnable, DECIDE, RUNMIN and APPLY set the run length
// and update the table. A run has at most about 3N decisions (arrivals, completions and
// idle gaps), since time jumps from one event to the next rather than per tick. Results then
// leave in index order via ORD, OS1, OS2, OS3 and OHOLD, which waits for res_ready; the
// last is flagged by last_result. Once it is taken the block is empty and takes the next batch.
`default_nettype none
module preemptive_priority_scheduler #(
	parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       rec_valid,
	output logic                            rec_ready,
	input  wire logic [pps_pkg::ARR_W-1:0]  arrival_time,
	input  wire logic [pps_pkg::BUR_W-1:0]  burst_length,
	input  wire logic [pps_pkg::PRI_W-1:0]  priority_level,
	input  wire logic                       last_record,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output logic      [pps_pkg::PIDX_W-1:0] proc_index,
	output logic      [pps_pkg::TIME_W-1:0] completion_time,
	output logic      [pps_pkg::TIME_W-1:0] turnaround_time,
	output logic      [pps_pkg::TIME_W-1:0] waiting_time,
	output logic      [pps_pkg::TIME_W-1:0] response_time,
	output logic      [pps_pkg::SUM_W-1:0]  sum_waiting,
	output logic      [pps_pkg::SUM_W-1:0]  sum_turnaround,
	output logic      [pps_pkg::SUM_W-1:0]  sum_response,
	output logic                            last_result
);

	localparam int IDX_W  = pps_pkg::idx_w(MAX_PROCS);
	localparam int CNT_W  = $clog2(MAX_PROCS + 1);
	localparam int TICK_W = pps_pkg::tick_w(MAX_PROCS);
	localparam int BUR_W  = pps_pkg::BUR_W;
	localparam int SUM_W  = pps_pkg::SUM_W;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_SCAN   = 11'b000_0000_0010,
		ST_SDRAIN = 11'b000_0000_0100,
		ST_DECIDE = 11'b000_0000_1000,
		ST_RUNMIN = 11'b000_0001_0000,
		ST_APPLY  = 11'b000_0010_0000,
		ST_ORD    = 11'b000_0100_0000,
		ST_OS1    = 11'b000_1000_0000,
		ST_OS2    = 11'b001_0000_0000,
		ST_OS3    = 11'b010_0000_0000,
		ST_OHOLD  = 11'b100_0000_0000
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       rec_cnt_q;
	logic [CNT_W-1:0]       fin_cnt_q;
	logic [TICK_W-1:0]      tick_q;
	logic [MAX_PROCS-1:0]   fin_q;
	logic [IDX_W-1:0]       scan_q;
	logic [IDX_W-1:0]       oidx_q;
	logic                   rd_vld_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic [SUM_W-1:0]       sum_w_q;
	logic [SUM_W-1:0]       sum_t_q;
	logic [SUM_W-1:0]       sum_r_q;

	logic [TICK_W-1:0]      diff_q;
	logic [BUR_W-1:0]       run_q;
	logic                   first_q;
	logic [TICK_W-1:0]      ct_q;
	logic [TICK_W-1:0]      tt_q;
	logic [TICK_W-1:0]      rt_q;
	logic [TICK_W-1:0]      wt_q;
	logic [BUR_W-1:0]       obur_q;
	logic                   olast_q;

	logic                   rec_xfer;
	logic                   res_xfer;
	logic                   room;
	logic [BUR_W-1:0]       bur_eff;
	logic                   scan_last;
	logic                   out_last;
	logic [BUR_W-1:0]       rem_new;
	logic                   done_now;
	logic [TICK_W-1:0]      tick_new;

	pps_pkg::rec_t          rec_wdata;
	pps_pkg::rec_t          rec_rdata;
	logic [IDX_W-1:0]       rec_raddr;
	logic [BUR_W-1:0]       rem_rdata;
	logic                   rem_we;
	logic [IDX_W-1:0]       rem_waddr;
	logic [BUR_W-1:0]       rem_wdata;
	logic [TICK_W-1:0]      start_rdata;
	logic [TICK_W-1:0]      comp_rdata;
	logic [IDX_W-1:0]       pick_idx;
	pps_pkg::pick_t         pk;

	assign rec_ready = (state_q == ST_IDLE);
	assign rec_xfer  = rec_valid && rec_ready;
	assign res_valid = (state_q == ST_OHOLD);
	assign res_xfer  = res_valid && res_ready;
	assign room      = (rec_cnt_q != CNT_W'(MAX_PROCS));
	assign bur_eff   = (burst_length == '0) ? BUR_W'(1) : burst_length;

	assign rec_wdata.pri = priority_level;
	assign rec_wdata.bur = bur_eff;
	assign rec_wdata.arr = arrival_time;

	assign scan_last = (CNT_W'(scan_q) + CNT_W'(1)) == rec_cnt_q;
	assign out_last  = (CNT_W'(oidx_q) + CNT_W'(1)) == rec_cnt_q;
	assign rem_new   = pk.rem - run_q;
	assign done_now  = (run_q == pk.rem);
	assign tick_new  = tick_q + TICK_W'(run_q);

	assign rec_raddr = (state_q == ST_SCAN) ? scan_q : oidx_q;
	assign rem_we    = (rec_xfer && room) || (state_q == ST_APPLY);
	assign rem_waddr = (state_q == ST_APPLY) ? pick_idx : rec_cnt_q[IDX_W-1:0];
	assign rem_wdata = (state_q == ST_APPLY) ? rem_new : bur_eff;

	pps_ram #(.WIDTH($bits(pps_pkg::rec_t)), .DEPTH(MAX_PROCS)) u_rec_ram (
		.clk   (clk),
		.we    (rec_xfer && room),
		.waddr (rec_cnt_q[IDX_W-1:0]),
		.wdata (rec_wdata),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	pps_ram #(.WIDTH(BUR_W), .DEPTH(MAX_PROCS)) u_rem_ram (
		.clk   (clk),
		.we    (rem_we),
		.waddr (rem_waddr),
		.wdata (rem_wdata),
		.raddr (scan_q),
		.rdata (rem_rdata)
	);

	pps_ram #(.WIDTH(TICK_W), .DEPTH(MAX_PROCS)) u_start_ram (
		.clk   (clk),
		.we    ((state_q == ST_APPLY) && first_q),
		.waddr (pick_idx),
		.wdata (tick_q),
		.raddr (oidx_q),
		.rdata (start_rdata)
	);

	pps_ram #(.WIDTH(TICK_W), .DEPTH(MAX_PROCS)) u_comp_ram (
		.clk   (clk),
		.we    ((state_q == ST_APPLY) && done_now),
		.waddr (pick_idx),
		.wdata (tick_new),
		.raddr (oidx_q),
		.rdata (comp_rdata)
	);

	pps_pick #(.MAX_PROCS(MAX_PROCS)) u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      ((state_q == ST_SCAN) && (scan_q == '0)),
		.vld      (rd_vld_s1),
		.idx      (rd_idx_s1),
		.rec      (rec_rdata),
		.rem      (rem_rdata),
		.done     (fin_q[rd_idx_s1]),
		.tick     (tick_q),
		.best_idx (pick_idx),
		.stat     (pk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rec_cnt_q <= '0;
			fin_cnt_q <= '0;
			tick_q    <= '0;
			fin_q     <= '0;
			scan_q    <= '0;
			oidx_q    <= '0;
			rd_vld_s1 <= 1'b0;
			sum_w_q   <= '0;
			sum_t_q   <= '0;
			sum_r_q   <= '0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (rec_xfer) begin
						if (room) begin
							rec_cnt_q <= rec_cnt_q + CNT_W'(1);
						end
						if (last_record) begin
							scan_q  <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_SDRAIN;
					end else begin
						scan_q <= scan_q + IDX_W'(1);
					end
				end
				ST_SDRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (!pk.have) begin
						// idle until the next arrival
						tick_q  <= TICK_W'(pk.next_arr);
						scan_q  <= '0;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_RUNMIN;
					end
				end
				ST_RUNMIN: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					tick_q <= tick_new;
					scan_q <= '0;
					if (done_now) begin
						fin_q[pick_idx] <= 1'b1;
						fin_cnt_q       <= fin_cnt_q + CNT_W'(1);
					end
					if (done_now && ((fin_cnt_q + CNT_W'(1)) == rec_cnt_q)) begin
						oidx_q  <= '0;
						sum_w_q <= '0;
						sum_t_q <= '0;
						sum_r_q <= '0;
						state_q <= ST_ORD;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_ORD: begin
					state_q <= ST_OS1;
				end
				ST_OS1: begin
					state_q <= ST_OS2;
				end
				ST_OS2: begin
					sum_t_q <= sum_t_q + SUM_W'(tt_q);
					sum_r_q <= sum_r_q + SUM_W'(rt_q);
					state_q <= ST_OS3;
				end
				ST_OS3: begin
					sum_w_q <= sum_w_q + SUM_W'(wt_q);
					state_q <= ST_OHOLD;
				end
				ST_OHOLD: begin
					if (res_xfer) begin
						if (olast_q) begin
							rec_cnt_q <= '0;
							fin_cnt_q <= '0;
							tick_q    <= '0;
							fin_q     <= '0;
							state_q   <= ST_IDLE;
						end else begin
							oidx_q  <= oidx_q + IDX_W'(1);
							state_q <= ST_ORD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q;
		if (state_q == ST_DECIDE) begin
			diff_q <= TICK_W'(pk.next_arr) - tick_q;
		end
		if (state_q == ST_RUNMIN) begin
			run_q   <= (pk.have_next && (diff_q < TICK_W'(pk.rem))) ?
			           diff_q[BUR_W-1:0] : pk.rem;
			first_q <= (pk.rem == pk.bur);
		end
		if (state_q == ST_OS1) begin
			ct_q   <= comp_rdata;
			tt_q   <= comp_rdata - TICK_W'(rec_rdata.arr);
			rt_q   <= start_rdata - TICK_W'(rec_rdata.arr);
			obur_q <= rec_rdata.bur;
		end
		if (state_q == ST_OS2) begin
			wt_q <= tt_q - TICK_W'(obur_q);
		end
		if (state_q == ST_OS3) begin
			olast_q <= out_last;
		end
	end

	assign proc_index      = pps_pkg::PIDX_W'(oidx_q);
	assign completion_time = pps_pkg::TIME_W'(ct_q);
	assign turnaround_time = pps_pkg::TIME_W'(tt_q);
	assign waiting_time    = pps_pkg::TIME_W'(wt_q);
	assign response_time   = pps_pkg::TIME_W'(rt_q);
	assign sum_waiting     = sum_w_q;
	assign sum_turnaround  = sum_t_q;
	assign sum_response    = sum_r_q;
	assign last_result     = olast_q;

	a_fin_le_rec: assert property (@(posedge clk) disable iff (!arst_n)
		fin_cnt_q <= rec_cnt_q)
		else $error("finished count exceeds record count");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |-> (run_q != '0) && (run_q <= pk.rem))
		else $error("run length out of range");

	a_idle_has_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) && !pk.have |-> pk.have_next)
		else $error("no runnable process and no future arrival");

	a_res_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (CNT_W'(oidx_q) < rec_cnt_q) && (fin_cnt_q == rec_cnt_q))
		else $error("result emitted outside a finished batch");

	a_tick_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |=> (tick_q > $past(tick_q)))
		else $error("time did not advance on a run");

endmodule
`default_nettype wire
